/* rtl/scp_pkg.sv */
// ----------------------------------------------------------------------------
// scp_pkg: shared types and constants of the section cycle profiler
// Command codes, the per-section record and the result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package scp_pkg;

  localparam int unsigned SECTIONS_DEF = 16;
  localparam int unsigned TS_W         = 32;
  localparam int unsigned SEC_FIELD_W  = 8;
  localparam int unsigned CMD_W        = 2;

  localparam logic [TS_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // One section's bookkeeping.
  typedef struct packed {
    logic [TS_W-1:0] start_stamp;
    logic [TS_W-1:0] last_elapsed;
    logic [TS_W-1:0] min_seen;
    logic [TS_W-1:0] max_seen;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    start_stamp:  '0,
    last_elapsed: '0,
    min_seen:     ALL_ONES,
    max_seen:     '0
  };

  // Result word handed to the output register.
  typedef struct packed {
    logic            accepted;
    logic [TS_W-1:0] elapsed_cycles;
    logic [TS_W-1:0] min_cycles;
    logic [TS_W-1:0] max_cycles;
  } result_t;

endpackage : scp_pkg

`default_nettype wire

/* rtl/section_cycle_profiler.sv */
// ----------------------------------------------------------------------------
// section_cycle_profiler: per-section execution time profiler
// Tracks start stamp, last elapsed time, minimum and maximum per section.
// ----------------------------------------------------------------------------
// Each input word carries a command (start, stop, clear), a section number
// and the current 32-bit cycle timestamp, and produces exactly one result
// word. A start records the timestamp, a stop stores the wrapping 32-bit
// difference to the recorded start and folds it into the section's minimum
// and maximum, and a clear returns the section to its reset values (zero
// stamp, elapsed and maximum, minimum of all ones). A section number at or
// above SECTIONS is not acted on and returns accepted = 0 with all values
// zero; the unused command code returns accepted = 0 with the section's
// unchanged values. The block accepts one word per clock cycle unless a held
// result stalls it. The section memory is read at the edge that accepts a
// word, the update runs from stage 1, and its result is registered into the
// output register, which raises out_valid, once that register is free. A
// result held by a low out_ready keeps one more word waiting in stage 1,
// after which in_ready drops until the result leaves. A word that follows
// a word for the same section in the next cycle sees the earlier update
// through a bypass of the write port. No memory clearing pass is needed
// after reset; per-section valid bits stand in for it.
// ----------------------------------------------------------------------------
`default_nettype none

module section_cycle_profiler
  import scp_pkg::*;
#(
  parameter int unsigned SECTIONS = SECTIONS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [CMD_W-1:0]       in_cmd,
  input  wire logic [SEC_FIELD_W-1:0] in_section,
  input  wire logic [TS_W-1:0]        in_timestamp,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_accepted,
  output logic [TS_W-1:0]             out_elapsed_cycles,
  output logic [TS_W-1:0]             out_min_cycles,
  output logic [TS_W-1:0]             out_max_cycles
);

  localparam int unsigned IDX_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

  // Stage 1 holds the accepted word while the memory read completes.
  logic                  s1_vld_r;
  logic                  s1_vld_nxt;
  logic [CMD_W-1:0]      s1_cmd_r;
  logic [IDX_W-1:0]      s1_idx_r;
  logic                  s1_in_range_r;
  logic [TS_W-1:0]       s1_ts_r;

  logic                  out_vld_r;
  logic                  out_vld_nxt;
  result_t               out_res_r;

  logic                  in_fire;
  logic                  s1_adv;
  logic                  in_range;
  logic [IDX_W-1:0]      in_idx;

  entry_t                cur_entry;
  entry_t                nxt_entry;
  logic                  wr_en;
  result_t               res;

  // The section field is compared one bit wider so SECTIONS = 256 fits.
  assign in_range = ({1'b0, in_section} < (SEC_FIELD_W + 1)'(SECTIONS));
  assign in_idx   = in_range ? in_section[IDX_W-1:0] : '0;

  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_fire) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (s1_adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r      <= in_cmd;
      s1_idx_r      <= in_idx;
      s1_in_range_r <= in_range;
      s1_ts_r       <= in_timestamp;
    end
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  scp_entry_store #(
    .SECTIONS (SECTIONS),
    .IDX_W    (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (in_idx),
    .wr_en   (s1_adv && wr_en),
    .wr_addr (s1_idx_r),
    .wr_data (nxt_entry),
    .rd_data (cur_entry)
  );

  scp_update u_update (
    .cmd       (s1_cmd_r),
    .in_range  (s1_in_range_r),
    .timestamp (s1_ts_r),
    .cur       (cur_entry),
    .wr_en     (wr_en),
    .nxt       (nxt_entry),
    .res       (res)
  );

  assign out_valid          = out_vld_r;
  assign out_accepted       = out_res_r.accepted;
  assign out_elapsed_cycles = out_res_r.elapsed_cycles;
  assign out_min_cycles     = out_res_r.min_cycles;
  assign out_max_cycles     = out_res_r.max_cycles;

endmodule : section_cycle_profiler

`default_nettype wire

/* rtl/scp_entry_store.sv */
// ----------------------------------------------------------------------------
// scp_entry_store: per-section record memory
// Registered-read memory with per-entry valid bits and write-to-read bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_entry_store
  import scp_pkg::*;
#(
  parameter int unsigned SECTIONS = SECTIONS_DEF,
  parameter int unsigned IDX_W    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire entry_t           wr_data,
  output entry_t                rd_data
);

  entry_t               mem [SECTIONS];
  logic [SECTIONS-1:0]  vld_r;
  entry_t               mem_rd_r;
  logic                 vld_rd_r;
  logic [IDX_W-1:0]     rd_addr_r;
  entry_t               fwd_r;
  logic [IDX_W-1:0]     fwd_addr_r;
  logic                 fwd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_rd_r  <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
    if (wr_en) begin
      fwd_r      <= wr_data;
      fwd_addr_r <= wr_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      vld_rd_r  <= 1'b0;
      fwd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
        fwd_vld_r      <= 1'b1;
      end
      if (rd_en) begin
        vld_rd_r <= vld_r[rd_addr];
      end
    end
  end

  // A write landing on the same edge as the read is not in mem_rd_r yet.
  always_comb begin
    if (fwd_vld_r && (fwd_addr_r == rd_addr_r)) begin
      rd_data = fwd_r;
    end else if (vld_rd_r) begin
      rd_data = mem_rd_r;
    end else begin
      rd_data = ENTRY_RESET;
    end
  end

endmodule : scp_entry_store

`default_nettype wire

/* rtl/scp_update.sv */
// ----------------------------------------------------------------------------
// scp_update: command execution for one section record
// Computes the new record, its write enable and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_update
  import scp_pkg::*;
(
  input  wire logic [CMD_W-1:0] cmd,
  input  wire logic             in_range,
  input  wire logic [TS_W-1:0]  timestamp,
  input  wire entry_t           cur,
  output logic                  wr_en,
  output entry_t                nxt,
  output result_t               res
);

  logic [TS_W-1:0] elapsed;
  logic            acted;

  assign elapsed = timestamp - cur.start_stamp;

  always_comb begin
    nxt   = cur;
    acted = 1'b1;
    unique case (cmd_t'(cmd))
      CMD_START: nxt.start_stamp = timestamp;
      CMD_STOP: begin
        nxt.last_elapsed = elapsed;
        if (cur.max_seen < elapsed) begin
          nxt.max_seen = elapsed;
        end
        if (cur.min_seen > elapsed) begin
          nxt.min_seen = elapsed;
        end
      end
      CMD_CLEAR: nxt = ENTRY_RESET;
      default:   acted = 1'b0;
    endcase
  end

  always_comb begin
    wr_en = in_range && acted;
    if (in_range) begin
      res.accepted       = acted;
      res.elapsed_cycles = nxt.last_elapsed;
      res.min_cycles     = nxt.min_seen;
      res.max_cycles     = nxt.max_seen;
    end else begin
      res = '0;
    end
  end

endmodule : scp_update

`default_nettype wire

/* sim/tb_scp_tracker_pkg.sv */
// ----------------------------------------------------------------------------
// tb_scp_tracker_pkg: expected-result tracker for the section cycle profiler
// Keeps its own copy of every section's bookkeeping, works out the result
// of each accepted input word and compares the block's results against it.
// ----------------------------------------------------------------------------
package tb_scp_tracker_pkg;
  import scp_pkg::*;

  class section_tracker;
    entry_t      book[SECTIONS_DEF];
    result_t     due[$];
    int unsigned errors;
    int unsigned seen;

    function new();
      foreach (book[i]) book[i] = ENTRY_RESET;
      errors = 0;
      seen   = 0;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    // Applies one accepted word to the local copy and queues its result.
    function void note_word(input logic [CMD_W-1:0] cmd,
                            input logic [SEC_FIELD_W-1:0] sec,
                            input logic [TS_W-1:0] stamp);
      result_t         res;
      logic [TS_W-1:0] span;
      res = '0;
      if (sec < SECTIONS_DEF) begin
        case (cmd)
          CMD_START: begin
            book[sec].start_stamp = stamp;
            res.accepted = 1'b1;
          end
          CMD_STOP: begin
            span = stamp - book[sec].start_stamp;
            book[sec].last_elapsed = span;
            if (book[sec].max_seen < span) book[sec].max_seen = span;
            if (book[sec].min_seen > span) book[sec].min_seen = span;
            res.accepted = 1'b1;
          end
          CMD_CLEAR: begin
            book[sec] = ENTRY_RESET;
            res.accepted = 1'b1;
          end
          default: ;
        endcase
        res.elapsed_cycles = book[sec].last_elapsed;
        res.min_cycles     = book[sec].min_seen;
        res.max_cycles     = book[sec].max_seen;
      end
      due.push_back(res);
    endfunction

    task report(input string what);
      if (errors < 100) $display("tb_scp: result %0d: %s", seen, what);
      errors++;
    endtask

    task check_word(input result_t got);
      result_t want;
      seen++;
      if (due.size() == 0) begin
        report("result arrived with no word outstanding");
        return;
      end
      want = due.pop_front();
      if (got.accepted !== want.accepted)
        report($sformatf("accepted %0b, expected %0b", got.accepted, want.accepted));
      if (got.elapsed_cycles !== want.elapsed_cycles)
        report($sformatf("elapsed_cycles %h, expected %h",
                         got.elapsed_cycles, want.elapsed_cycles));
      if (got.min_cycles !== want.min_cycles)
        report($sformatf("min_cycles %h, expected %h", got.min_cycles, want.min_cycles));
      if (got.max_cycles !== want.max_cycles)
        report($sformatf("max_cycles %h, expected %h", got.max_cycles, want.max_cycles));
    endtask
  endclass

endpackage : tb_scp_tracker_pkg

/* sim/tb_section_cycle_profiler.sv */
// ----------------------------------------------------------------------------
// tb_section_cycle_profiler: self-checking bench of the section cycle profiler
// Drives start, stop, clear and unused-command words with random idling on both
// channels and checks every result word against a tracker that mirrors each section.
// ----------------------------------------------------------------------------
module tb_section_cycle_profiler;
  import scp_pkg::*;
  import tb_scp_tracker_pkg::*;

  localparam int unsigned WORD_TARGET = 1950;
  // Longest honest quiet stretch is a sender gap plus a receiver stall plus
  // the trip through stage 1 and the output register.
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned TAIL_CYCLES = 16;
  // The one command code that the block must leave alone.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [CMD_W-1:0]       in_cmd;
  logic [SEC_FIELD_W-1:0] in_section;
  logic [TS_W-1:0]        in_timestamp;
  logic                   out_valid;
  logic                   out_ready;
  logic                   out_accepted;
  logic [TS_W-1:0]        out_elapsed_cycles;
  logic [TS_W-1:0]        out_min_cycles;
  logic [TS_W-1:0]        out_max_cycles;

  // When set, neither side idles, so words stream back to back.
  bit             burst_mode;
  section_tracker tracker;

  section_cycle_profiler #(
    .SECTIONS (SECTIONS_DEF)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_section         (in_section),
    .in_timestamp       (in_timestamp),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_accepted       (out_accepted),
    .out_elapsed_cycles (out_elapsed_cycles),
    .out_min_cycles     (out_min_cycles),
    .out_max_cycles     (out_max_cycles)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offers one word after a random gap and returns at the rising edge that
  // accepts it, having handed the word to the tracker. Inputs only change on
  // the falling edge, so the block always sees a settled word.
  task automatic send_word(input logic [CMD_W-1:0] cmd,
                           input logic [SEC_FIELD_W-1:0] sec,
                           input logic [TS_W-1:0] stamp);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_section   <= sec;
    in_timestamp <= stamp;
    do @(posedge clk); while (in_ready !== 1'b1);
    tracker.note_word(cmd, sec, stamp);
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Result side: stalls a random number of cycles before each word, then
  // takes whatever the block offers and checks it.
  initial begin : result_sink
    int unsigned stall;
    result_t     got;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 11);
      @(negedge clk);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.accepted       = out_accepted;
      got.elapsed_cycles = out_elapsed_cycles;
      got.min_cycles     = out_min_cycles;
      got.max_cycles     = out_max_cycles;
      tracker.check_word(got);
    end
  end

  // Watchdog: too many cycles without a single handshake ends the run.
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("tb_section_cycle_profiler: errors");
    $finish;
  end

  initial begin : stimulus
    logic [TS_W-1:0]        stamp_now;
    logic [TS_W-1:0]        stamp;
    logic [TS_W-1:0]        span;
    logic [SEC_FIELD_W-1:0] sec;
    logic [CMD_W-1:0]       cmd;
    bit                     open_start[SECTIONS_DEF];
    logic [TS_W-1:0]        open_stamp[SECTIONS_DEF];
    int unsigned            counted;
    int unsigned            step;
    int unsigned            pick;

    tracker      = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_cmd       = CMD_START;
    in_section   = '0;
    in_timestamp = '0;
    burst_mode   = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words, streamed back to back so that several hit the same
    // section in consecutive cycles.
    // A stop with no start measures from the zero stamp left by reset.
    send_word(CMD_STOP, 8'd0, 32'h0000_0010);
    // A start near the top of the counter and a stop after it wrapped.
    send_word(CMD_START, 8'd1, 32'hFFFF_FFF0);
    send_word(CMD_STOP, 8'd1, 32'h0000_000F);
    // A zero elapsed time pulls the minimum to zero.
    send_word(CMD_STOP, 8'd1, 32'hFFFF_FFF0);
    // The largest possible elapsed time, on the highest section.
    send_word(CMD_START, 8'd15, 32'h0000_0000);
    send_word(CMD_STOP, 8'd15, 32'hFFFF_FFFF);
    // After a clear the minimum reads all ones and the stamp is zero again.
    send_word(CMD_CLEAR, 8'd15, 32'hFFFF_FFFF);
    send_word(CMD_STOP, 8'd15, 32'h8000_0000);
    // The unused command, in range and out of range.
    send_word(CMD_UNUSED, 8'd1, 32'h5555_5555);
    send_word(CMD_UNUSED, 8'd200, 32'hAAAA_AAAA);
    // Sections at and beyond the count are flagged and leave state alone.
    send_word(CMD_START, 8'd16, 32'h1234_5678);
    send_word(CMD_STOP, 8'd255, 32'hFFFF_FFFF);
    send_word(CMD_CLEAR, 8'd128, 32'h0000_0000);
    // Back-to-back stops on one section move both the minimum and maximum.
    send_word(CMD_START, 8'd2, 32'd100);
    send_word(CMD_STOP, 8'd2, 32'd350);
    send_word(CMD_STOP, 8'd2, 32'd300);
    send_word(CMD_STOP, 8'd2, 32'd400);
    // A start on an untouched section still shows the all-ones minimum.
    send_word(CMD_START, 8'd4, 32'd7);
    send_word(CMD_CLEAR, 8'd0, 32'd0);
    drain();

    // Random part. Most words are start and stop pairs per section with
    // random spans, mixed with stray commands, clears and flagged words.
    stamp_now = $urandom();
    counted   = 0;
    step      = 0;
    while (counted < WORD_TARGET) begin
      if (step % 64 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      if (step % 500 == 499) drain();
      stamp_now = stamp_now + $urandom_range(1, 300);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        sec = SEC_FIELD_W'($urandom_range(0, SECTIONS_DEF - 1));
        if (open_start[sec]) begin
          // Mostly short spans, some long ones, and a few that wrap.
          pick = $urandom_range(0, 9);
          if (pick < 6) span = $urandom_range(0, 2000);
          else if (pick < 9) span = $urandom_range(0, 1 << 20);
          else span = $urandom();
          send_word(CMD_STOP, sec, open_stamp[sec] + span);
          open_start[sec] = 1'b0;
        end else begin
          send_word(CMD_START, sec, stamp_now);
          open_start[sec] = 1'b1;
          open_stamp[sec] = stamp_now;
        end
        counted++;
      end else if (pick < 75) begin
        sec   = SEC_FIELD_W'($urandom_range(0, SECTIONS_DEF - 1));
        cmd   = ($urandom_range(0, 1) != 0) ? CMD_STOP : CMD_START;
        stamp = $urandom();
        send_word(cmd, sec, stamp);
        open_start[sec] = (cmd == CMD_START);
        open_stamp[sec] = stamp;
        counted++;
      end else if (pick < 85) begin
        sec = SEC_FIELD_W'($urandom_range(0, SECTIONS_DEF - 1));
        send_word(CMD_CLEAR, sec, $urandom());
        open_start[sec] = 1'b0;
        counted++;
      end else if (pick < 95) begin
        sec = SEC_FIELD_W'($urandom_range(SECTIONS_DEF, 255));
        cmd = CMD_W'($urandom_range(0, 3));
        send_word(cmd, sec, $urandom());
        counted++;
      end else begin
        sec = SEC_FIELD_W'($urandom_range(0, 255));
        send_word(CMD_UNUSED, sec, $urandom());
        counted++;
      end
      step++;
    end

    // Let the pipeline empty, then watch a little longer for strays.
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("tb_section_cycle_profiler: clean");
    end else begin
      $display("tb_section_cycle_profiler: errors");
    end
    $finish;
  end

endmodule : tb_section_cycle_profiler

/* sim.f */
rtl/scp_pkg.sv
rtl/scp_entry_store.sv
rtl/scp_update.sv
rtl/section_cycle_profiler.sv
sim/tb_scp_tracker_pkg.sv
sim/tb_section_cycle_profiler.sv
